FILE: rtl/otle_pkg.sv
`timescale 1ns / 1ps

package otle_pkg;

    localparam int MAX_DEPTH    = 8;
    localparam int NUM_FEATURES = 256;
    localparam int LEAF_COUNT   = 1 << MAX_DEPTH;

    localparam int IDX_W     = 8;
    localparam int VAL_W     = 32;
    localparam int BYTE_W    = 8;
    localparam int LVL_W     = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 4;
    localparam int ACT_W     = 2;

    // slave tdata: index, split_feature_id, value, base_sum
    localparam int S_TDATA_W = 2 * IDX_W + 2 * VAL_W;
    // master tdata: leaf_index, leaf_value
    localparam int M_TDATA_W = IDX_W + VAL_W;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVELS_IN_USE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCUMULATE_MODE = 1'b1;

    typedef enum logic [ACT_W-1:0] {
        ACT_SPLIT   = 2'd0,
        ACT_LEAF    = 2'd1,
        ACT_FEATURE = 2'd2
    } t_action;

    typedef logic [MAX_DEPTH-1:0] t_bits;

    // leaf lookup issued on the last byte of a row
    typedef struct packed {
        logic                    rd;
        t_bits                   bits;
        logic                    accum;
        logic signed [VAL_W-1:0] base_sum;
    } t_leaf_req;

    typedef struct packed {
        logic             we;
        t_bits            addr;
        logic [VAL_W-1:0] data;
    } t_leaf_wr;

endpackage

FILE: rtl/otle_split_eval.sv
`timescale 1ns / 1ps

module otle_split_eval
    import otle_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  t_action                 i_action,
    input  logic [IDX_W-1:0]        i_index,
    input  logic [IDX_W-1:0]        i_split_feature_id,
    input  logic [VAL_W-1:0]        i_value,
    input  logic signed [VAL_W-1:0] i_base_sum,
    input  logic                    i_last,
    input  logic [LVL_W-1:0]        i_levels_in_use,
    input  logic                    i_accumulate_mode,
    output t_leaf_req               o_req
);

    logic [IDX_W-1:0]  r_split_feature   [MAX_DEPTH];
    logic [BYTE_W-1:0] r_split_threshold [MAX_DEPTH];
    t_bits             r_row_bits;

    logic [LVL_W-1:0] used;
    logic             feat_ok;
    logic             is_feat;
    logic             is_split;
    t_bits            hits;
    t_bits            next_bits;

    always_comb begin
        used = (i_levels_in_use > LVL_W'(MAX_DEPTH)) ? LVL_W'(MAX_DEPTH) : i_levels_in_use;
        feat_ok  = ({1'b0, i_index} < (IDX_W + 1)'(NUM_FEATURES));
        is_feat  = i_accept && (i_action == ACT_FEATURE);
        is_split = i_accept && (i_action == ACT_SPLIT);
        // all levels compare in parallel
        for (int l = 0; l < MAX_DEPTH; l++) begin
            hits[l] = (LVL_W'(l) < used) && feat_ok
                      && (r_split_feature[l] == i_index)
                      && (i_value[BYTE_W-1:0] > r_split_threshold[l]);
        end
        next_bits = r_row_bits | hits;
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < MAX_DEPTH; l++) begin
            if (is_split && (i_index == IDX_W'(l))) begin
                r_split_feature[l]   <= i_split_feature_id;
                r_split_threshold[l] <= i_value[BYTE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bits <= '0;
        end else if (is_feat) begin
            r_row_bits <= i_last ? '0 : next_bits;
        end
    end

    assign o_req.rd       = is_feat && i_last;
    assign o_req.bits     = next_bits;
    assign o_req.accum    = i_accumulate_mode;
    assign o_req.base_sum = i_base_sum;

    a_row_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_feat && i_last) |=> (r_row_bits == '0))
        else $error("row bits not cleared after last byte");

    a_bits_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_feat && !i_last) |=> ((r_row_bits & $past(r_row_bits)) == $past(r_row_bits)))
        else $error("row bit dropped mid-row");

endmodule

FILE: rtl/otle_leaf_stage.sv
`timescale 1ns / 1ps

module otle_leaf_stage
    import otle_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_leaf_req               i_req,
    input  t_leaf_wr                i_wr,
    input  logic                    i_m_ready,
    output logic                    o_free,
    output logic                    o_m_valid,
    output logic [IDX_W-1:0]        o_leaf_index,
    output logic signed [VAL_W-1:0] o_leaf_value
);

    logic [VAL_W-1:0] leaf_mem [LEAF_COUNT];

    logic [VAL_W-1:0]        r_rd_data;
    logic                    r_s1_valid;
    t_bits                   r_s1_bits;
    logic                    r_s1_accum;
    logic signed [VAL_W-1:0] r_s1_base;

    logic                    r_out_valid;
    logic [IDX_W-1:0]        r_out_index;
    logic signed [VAL_W-1:0] r_out_value;

    logic                    s1_adv;
    logic signed [VAL_W:0]   sum;
    logic signed [VAL_W-1:0] n_value;

    // write and read never share a cycle: one beat per cycle at most
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            leaf_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_req.rd) begin
            r_rd_data <= leaf_mem[i_req.bits];
        end
    end

    always_comb begin
        s1_adv = r_s1_valid && (!r_out_valid || i_m_ready);
        o_free = !r_s1_valid || s1_adv;
        sum    = {r_s1_base[VAL_W-1], r_s1_base}
                 + {r_rd_data[VAL_W-1], $signed(r_rd_data)};
        if (!r_s1_accum) begin
            n_value = $signed(r_rd_data);
        end else if (sum[VAL_W] != sum[VAL_W-1]) begin
            n_value = sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
            n_value = sum[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.rd) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_s1_bits  <= i_req.bits;
            r_s1_accum <= i_req.accum;
            r_s1_base  <= i_req.base_sum;
        end
        if (s1_adv) begin
            r_out_index <= IDX_W'(r_s1_bits);
            r_out_value <= n_value;
        end
    end

    assign o_m_valid    = r_out_valid;
    assign o_leaf_index = r_out_index;
    assign o_leaf_value = r_out_value;

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |-> !i_req.rd)
        else $error("leaf read issued while stage 1 is held");

    a_s1_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid)
        else $error("stage 1 result lost on the way to the output");

endmodule

FILE: rtl/oblivious_tree_leaf_eval_top.sv
`timescale 1ns / 1ps

// Channel   | Dir | Handshake                         | Payload
// ----------+-----+-----------------------------------+----------------------------------------
// s_axis    | in  | i_s_axis_tvalid / o_s_axis_tready | tdata, tuser = action, tlast = last
// m_axis    | out | o_m_axis_tvalid / i_m_axis_tready | tdata = leaf_index, leaf_value
// cfg       | in  | i_cfg_we (no wait)                | i_cfg_idx, i_cfg_wdata
//
// One beat per cycle while the output is not held back. Split compares for all
// levels run in parallel on the beat.
// After the last byte the leaf RAM read is registered with the row, then the
// Q16.16 add and saturation (accumulate mode only) go into the output register.
// Reset (sync, active low) clears row bits, config and valid flags; split and
// leaf tables are not cleared, so each entry must be written before use.
// A stalled output holds the result; the input keeps flowing until a second
// result is stuck behind it in the RAM read stage, then tready drops.

module oblivious_tree_leaf_eval_top
    import otle_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,  // index[7:0], split_feature_id[15:8],
                                                  // value[47:16], base_sum[79:48]
    input  logic [ACT_W-1:0]     i_s_axis_tuser,  // action[1:0]
    input  logic                 i_s_axis_tlast,
    // master stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,  // leaf_index[7:0], leaf_value[39:8]
    // config write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_wdata
);

    logic [LVL_W-1:0] r_levels_in_use;
    logic             r_accumulate_mode;

    logic                    accept;
    t_action                 action;
    logic [IDX_W-1:0]        index;
    logic [IDX_W-1:0]        split_feature_id;
    logic [VAL_W-1:0]        value;
    logic signed [VAL_W-1:0] base_sum;

    t_leaf_req               leaf_req;
    t_leaf_wr                leaf_wr;
    logic                    free;
    logic [IDX_W-1:0]        leaf_index;
    logic signed [VAL_W-1:0] leaf_value;

    // unpack the beat
    assign action           = t_action'(i_s_axis_tuser);
    assign index            = i_s_axis_tdata[IDX_W-1:0];
    assign split_feature_id = i_s_axis_tdata[2*IDX_W-1:IDX_W];
    assign value            = i_s_axis_tdata[2*IDX_W+VAL_W-1:2*IDX_W];
    assign base_sum         = $signed(i_s_axis_tdata[2*IDX_W+2*VAL_W-1:2*IDX_W+VAL_W]);

    assign o_s_axis_tready = free;
    assign accept          = i_s_axis_tvalid && free;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels_in_use   <= '0;
            r_accumulate_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LEVELS_IN_USE:   r_levels_in_use   <= i_cfg_wdata[LVL_W-1:0];
                CFG_ACCUMULATE_MODE: r_accumulate_mode <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // leaf write goes straight to the RAM; out-of-range leaf numbers dropped
    assign leaf_wr.we   = accept && (action == ACT_LEAF)
                          && ({1'b0, index} < (IDX_W + 1)'(LEAF_COUNT));
    assign leaf_wr.addr = index[MAX_DEPTH-1:0];
    assign leaf_wr.data = value;

    otle_split_eval u_split (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_action           (action),
        .i_index            (index),
        .i_split_feature_id (split_feature_id),
        .i_value            (value),
        .i_base_sum         (base_sum),
        .i_last             (i_s_axis_tlast),
        .i_levels_in_use    (r_levels_in_use),
        .i_accumulate_mode  (r_accumulate_mode),
        .o_req              (leaf_req)
    );

    otle_leaf_stage u_leaf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (leaf_req),
        .i_wr         (leaf_wr),
        .i_m_ready    (i_m_axis_tready),
        .o_free       (free),
        .o_m_valid    (o_m_axis_tvalid),
        .o_leaf_index (leaf_index),
        .o_leaf_value (leaf_value)
    );

    assign o_m_axis_tdata = {leaf_value, leaf_index};

    a_stall_only_on_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled without output backpressure");

    a_no_result_from_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (action != ACT_FEATURE)) |-> !leaf_req.rd)
        else $error("leaf lookup issued for a non-feature beat");

endmodule

FILE: bench/oblivious_tree_leaf_eval_top_tb.sv
`timescale 1ns / 1ps

module oblivious_tree_leaf_eval_top_tb;
    import otle_pkg::*;

    // action code that the block must drop without a result
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int     CYCLE_LIMIT  = 300000;
    localparam int     DRAIN_CYCLES = 4;     // leaf read + add stage, plus margin
    localparam int     RAND_ITEMS   = 19;    // per random segment, six segments
    localparam int     LVL_IDX_W    = $clog2(MAX_DEPTH);
    localparam longint S32_MAX      = 64'sd2147483647;
    localparam longint S32_MIN      = -64'sd2147483648;

    // one input beat, fields as the block sees them
    typedef struct {
        logic [ACT_W-1:0] action;
        logic [IDX_W-1:0] index;
        logic [IDX_W-1:0] feat_id;
        logic [VAL_W-1:0] value;
        logic [VAL_W-1:0] base_sum;
        logic             last;
    } t_beat;

    typedef struct {
        logic [IDX_W-1:0] leaf_idx;
        logic [VAL_W-1:0] leaf_val;
    } t_leaf_res;

    typedef enum logic {VEC_BEAT, VEC_CFG} t_vec_kind;

    // directed table row: either a beat (optionally with a hand-typed result)
    // or a register setting applied once the block is idle
    typedef struct {
        t_vec_kind         kind;
        t_beat             beat;
        bit                typed;
        t_leaf_res         want;
        logic [LVL_W-1:0]  lvl;
        logic              acc;
    } t_vec;

    logic                 i_clk;
    logic                 i_rst_n         = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata  = '0;  // index[7:0], split_feature_id[15:8],
                                                 // value[47:16], base_sum[79:48]
    logic [ACT_W-1:0]     i_s_axis_tuser  = '0;  // action[1:0]
    logic                 i_s_axis_tlast  = 1'b0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;        // leaf_index[7:0], leaf_value[39:8]
    logic                 i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx       = '0;
    logic [CFG_DAT_W-1:0] i_cfg_wdata     = '0;

    oblivious_tree_leaf_eval_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Tree mirror: split table, leaf table, row bits and the two registers
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]  split_feat [MAX_DEPTH];
    logic [BYTE_W-1:0] split_thr  [MAX_DEPTH];
    logic [VAL_W-1:0]  leaf_mem   [LEAF_COUNT];
    t_bits             row_acc = '0;
    logic [LVL_W-1:0]  lvl_cfg = '0;
    logic              acc_cfg = 1'b0;

    t_leaf_res pending_leaves[$];   // leaf results still owed by the block
    t_leaf_res want_leaf;
    int        errors      = 0;
    int        cycle_count = 0;
    int        tx_idle_pct = 28;
    int        rx_idle_pct = 65;
    int        row_left    = 0;     // feature beats left in the current random row

    // Apply one accepted beat to the mirror; returns 1 when it ends a row.
    function automatic bit tree_step(input t_beat b, output t_leaf_res r);
        int unsigned used;
        int          lv;
        longint      sum;
        r = '{default: '0};
        // level count above the table depth behaves as the full depth
        used = (lvl_cfg > MAX_DEPTH) ? MAX_DEPTH : lvl_cfg;
        case (b.action)
            ACT_SPLIT: begin
                if (b.index < MAX_DEPTH) begin
                    split_feat[b.index[LVL_IDX_W-1:0]] = b.feat_id;
                    split_thr[b.index[LVL_IDX_W-1:0]]  = b.value[BYTE_W-1:0];
                end
                return 1'b0;
            end
            ACT_LEAF: begin
                leaf_mem[b.index] = b.value;
                return 1'b0;
            end
            ACT_FEATURE: begin
                // strict compare on the low byte only; set bits are sticky
                for (lv = 0; lv < MAX_DEPTH; lv++)
                    if (lv < used && split_feat[lv] == b.index &&
                        b.value[BYTE_W-1:0] > split_thr[lv])
                        row_acc[lv] = 1'b1;
                if (!b.last)
                    return 1'b0;
                sum = longint'($signed(leaf_mem[row_acc]));
                if (acc_cfg) begin
                    sum += longint'($signed(b.base_sum));
                    if (sum > S32_MAX) sum = S32_MAX;
                    if (sum < S32_MIN) sum = S32_MIN;
                end
                r.leaf_idx = row_acc;
                r.leaf_val = sum[VAL_W-1:0];
                row_acc    = '0;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_vec dv(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                                input logic [IDX_W-1:0] fid, input logic [VAL_W-1:0] val,
                                input logic [VAL_W-1:0] base, input logic last,
                                input bit typed = 1'b0, input logic [IDX_W-1:0] eidx = '0,
                                input logic [VAL_W-1:0] eval = '0);
        t_vec v;
        v = '{kind: VEC_BEAT, default: '0};
        v.beat  = '{act, idx, fid, val, base, last};
        v.typed = typed;
        v.want  = '{eidx, eval};
        return v;
    endfunction

    function automatic t_vec cv(input logic [LVL_W-1:0] lvl, input logic acc);
        t_vec v;
        v = '{kind: VEC_CFG, default: '0};
        v.lvl  = lvl;
        v.acc  = acc;
        return v;
    endfunction

    // Q16.16 value, biased toward the saturation corners
    function automatic logic [VAL_W-1:0] rand_q16();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Mostly well-formed rows that hit the loaded splits, with table
    // rewrites and dropped-action noise mixed in. Rows may straddle segments.
    function automatic t_beat rand_item();
        t_beat b;
        int    pick;
        int    lv;
        pick       = $urandom_range(0, 99);
        b.action   = ACT_FEATURE;
        b.index    = IDX_W'($urandom());
        b.feat_id  = IDX_W'($urandom());
        b.value    = $urandom();
        b.base_sum = rand_q16();
        b.last     = 1'($urandom_range(0, 1));
        if (pick < 6) begin
            b.action = ACT_SPLIT;
            if (pick < 5)
                b.index = IDX_W'($urandom_range(0, MAX_DEPTH - 1));
        end else if (pick < 12) begin
            b.action = ACT_LEAF;
            b.value  = rand_q16();
        end else if (pick < 15) begin
            b.action = ACT_UNUSED;
        end else begin
            lv = $urandom_range(0, MAX_DEPTH - 1);
            if ($urandom_range(0, 3) != 0)
                b.index = split_feat[lv];
            // land on or just past the threshold now and then
            if ($urandom_range(0, 3) == 0)
                b.value[BYTE_W-1:0] = split_thr[lv] + BYTE_W'($urandom_range(0, 1));
            if (row_left == 0)
                row_left = $urandom_range(1, 8);
            row_left--;
            b.last = (row_left == 0);
        end
        return b;
    endfunction

    // Present one beat after a random gap, wait for the handshake, then
    // update the mirror. A typed result overrides the mirror's prediction.
    task automatic send_beat(input t_beat b, input bit typed = 1'b0,
                             input t_leaf_res want = '{default: '0});
        t_leaf_res got;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {b.base_sum, b.value, b.feat_id, b.index};
        i_s_axis_tuser  <= b.action;
        i_s_axis_tlast  <= b.last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (tree_step(b, got))
            pending_leaves.push_back(typed ? want : got);
    endtask

    // Registers change only with the block idle: stop sending, let every
    // owed result drain, give the pipeline its latency, then write both.
    task automatic program_regs(input logic [LVL_W-1:0] lvl, input logic acc);
        i_s_axis_tvalid <= 1'b0;
        while (pending_leaves.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_LEVELS_IN_USE;
        i_cfg_wdata <= lvl;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_ACCUMULATE_MODE;
        i_cfg_wdata <= {{(CFG_DAT_W - 1){1'b0}}, acc};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        lvl_cfg = lvl;
        acc_cfg = acc;
    endtask

    // ------------------------------------------------------------------
    // Result side: random backpressure and in-order field check
    // ------------------------------------------------------------------
    always @(posedge i_clk)
        i_m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_leaves.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tdata %h",
                         $time, o_m_axis_tdata);
                errors++;
            end else begin
                want_leaf = pending_leaves.pop_front();
                if (o_m_axis_tdata[IDX_W-1:0] !== want_leaf.leaf_idx) begin
                    $display("%0t: leaf_index expected %h actual %h",
                             $time, want_leaf.leaf_idx, o_m_axis_tdata[IDX_W-1:0]);
                    errors++;
                end
                if (o_m_axis_tdata[IDX_W +: VAL_W] !== want_leaf.leaf_val) begin
                    $display("%0t: leaf_value expected %h actual %h",
                             $time, want_leaf.leaf_val, o_m_axis_tdata[IDX_W +: VAL_W]);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_vec             tab[$];
        t_beat            b;
        int               seg;
        int               n;
        logic [LVL_W-1:0] seg_lvl [6];
        logic             seg_acc [6];

        // per-segment settings, extremes included
        seg_lvl = '{4'd8, 4'd3, 4'd1, 4'd8, 4'd0, 4'd5};
        seg_acc = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

        // Directed table. Leaf 0 = max, leaf 1 = min, leaf 3 = 1.0;
        // levels 0 and 1 both test feature 0xFF, thresholds 0x00 and 0xFE.
        tab.push_back(cv(4'd0, 1'b0));
        tab.push_back(dv(ACT_LEAF, 8'd0, 8'h00, 32'h7FFF_FFFF, 32'h0, 1'b0));
        // no levels in use: always leaf 0
        tab.push_back(dv(ACT_FEATURE, 8'h00, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                         1'b1, 8'd0, 32'h7FFF_FFFF));
        // wide threshold: only the low byte counts
        tab.push_back(dv(ACT_SPLIT, 8'd0, 8'hFF, 32'hFFFF_FF00, 32'h0, 1'b0));
        tab.push_back(dv(ACT_SPLIT, 8'd1, 8'hFF, 32'h0000_00FE, 32'h0, 1'b1));
        // split levels past the table depth are dropped
        tab.push_back(dv(ACT_SPLIT, 8'd8, 8'h00, 32'h0, 32'h0, 1'b0));
        tab.push_back(dv(ACT_SPLIT, 8'hFF, 8'h00, 32'h0, 32'h0, 1'b0));
        tab.push_back(dv(ACT_LEAF, 8'd1, 8'h00, 32'h8000_0000, 32'h0, 1'b0));
        tab.push_back(dv(ACT_LEAF, 8'd3, 8'h00, 32'h0001_0000, 32'h0, 1'b0));
        // dropped action and a write with last set: neither gives a result
        tab.push_back(dv(ACT_UNUSED, 8'h00, 8'h00, 32'h0, 32'h0, 1'b1));
        tab.push_back(dv(ACT_LEAF, 8'd255, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        tab.push_back(cv(4'd2, 1'b0));
        // sticky bit: the repeat with byte 0 leaves bit 0 set
        tab.push_back(dv(ACT_FEATURE, 8'hFF, 8'h00, 32'h0000_0001, 32'h0, 1'b0));
        tab.push_back(dv(ACT_FEATURE, 8'hFF, 8'h00, 32'hFFFF_FF00, 32'h0, 1'b0));
        tab.push_back(dv(ACT_FEATURE, 8'h7F, 8'h00, 32'h0000_00FF, 32'h0, 1'b1,
                         1'b1, 8'd1, 32'h8000_0000));
        tab.push_back(dv(ACT_FEATURE, 8'hFF, 8'h00, 32'h0000_00FF, 32'h0, 1'b1,
                         1'b1, 8'd3, 32'h0001_0000));
        // byte equal to the threshold does not set the bit
        tab.push_back(dv(ACT_FEATURE, 8'hFF, 8'h00, 32'h0000_00FE, 32'h0, 1'b1,
                         1'b1, 8'd1, 32'h8000_0000));
        // accumulate: clamp high, clamp low, plain sum
        tab.push_back(cv(4'd2, 1'b1));
        tab.push_back(dv(ACT_FEATURE, 8'hFF, 8'h00, 32'h0000_00FF, 32'h7FFF_FFFF, 1'b1,
                         1'b1, 8'd3, 32'h7FFF_FFFF));
        tab.push_back(dv(ACT_FEATURE, 8'hFF, 8'h00, 32'h0000_0001, 32'h8000_0000, 1'b1,
                         1'b1, 8'd1, 32'h8000_0000));
        tab.push_back(dv(ACT_FEATURE, 8'h00, 8'h00, 32'h0000_0000, 32'hFFFF_0000, 1'b1,
                         1'b1, 8'd0, 32'h7FFE_FFFF));
        // register change in the middle of a row, level count over the depth
        tab.push_back(dv(ACT_FEATURE, 8'hFF, 8'h00, 32'h0000_0001, 32'h0, 1'b0));
        tab.push_back(cv(4'd15, 1'b0));
        tab.push_back(dv(ACT_FEATURE, 8'hFF, 8'h00, 32'h0000_00FF, 32'h0, 1'b1));
        tab.push_back(cv(4'd8, 1'b1));
        tab.push_back(dv(ACT_FEATURE, 8'hFF, 8'h00, 32'h0000_00FF, 32'hC000_0000, 1'b1));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Load every split and every leaf first so that no row ever reads
        // an entry that was never written.
        for (n = 0; n < MAX_DEPTH + LEAF_COUNT; n++) begin
            b.action   = (n < MAX_DEPTH) ? ACT_SPLIT : ACT_LEAF;
            b.index    = IDX_W'((n < MAX_DEPTH) ? n : n - MAX_DEPTH);
            b.feat_id  = IDX_W'($urandom());
            b.value    = (n < MAX_DEPTH) ? $urandom() : rand_q16();
            b.base_sum = $urandom();
            b.last     = 1'($urandom_range(0, 1));
            send_beat(b);
        end

        foreach (tab[i]) begin
            if (tab[i].kind == VEC_CFG)
                program_regs(tab[i].lvl, tab[i].acc);
            else
                send_beat(tab[i].beat, tab[i].typed, tab[i].want);
        end

        // Random part: receiver-heavy idling, then sender-heavy, then none;
        // two register settings per idling pattern.
        for (seg = 0; seg < 6; seg++) begin
            case (seg / 2)
                0:       begin tx_idle_pct = 28; rx_idle_pct = 65; end
                1:       begin tx_idle_pct = 65; rx_idle_pct = 28; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            program_regs(seg_lvl[seg], seg_acc[seg]);
            repeat (RAND_ITEMS) send_beat(rand_item());
        end

        i_s_axis_tvalid <= 1'b0;
        while (pending_leaves.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES * 4) @(posedge i_clk);

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/otle_pkg.sv
rtl/otle_split_eval.sv
rtl/otle_leaf_stage.sv
rtl/oblivious_tree_leaf_eval_top.sv
bench/oblivious_tree_leaf_eval_top_tb.sv
